/* design/rna_pkg.sv */
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// rna_pkg: shared types and codes for the rational number ALU
// Transfer payloads, action and compare codes, and the sequencer states.
// ----------------------------------------------------------------------------
package rna_pkg;

  typedef enum logic [2:0] {
    ACT_ADD = 3'd0,
    ACT_SUB = 3'd1,
    ACT_MUL = 3'd2,
    ACT_DIV = 3'd3,
    ACT_CMP = 3'd4,
    ACT_INT = 3'd5
  } action_e;

  localparam logic [1:0] ORD_NONE    = 2'd0;
  localparam logic [1:0] ORD_LESS    = 2'd0;
  localparam logic [1:0] ORD_EQUAL   = 2'd1;
  localparam logic [1:0] ORD_GREATER = 2'd2;

  // Operand slots in the operand register file.
  localparam int unsigned OP_AN = 0;
  localparam int unsigned OP_AD = 1;
  localparam int unsigned OP_BN = 2;
  localparam int unsigned OP_BD = 3;
  localparam int unsigned NUM_OPS = 4;

  // Products formed by the shared multiplier for one item.
  localparam int unsigned MUL_STEPS = 3;

  typedef enum logic [6:0] {
    ST_IDLE = 7'b0000001,
    ST_MUL  = 7'b0000010,
    ST_SUM  = 7'b0000100,
    ST_GCD  = 7'b0001000,
    ST_DIVN = 7'b0010000,
    ST_DIVD = 7'b0100000,
    ST_OUT  = 7'b1000000
  } state_e;

  typedef struct packed {
    logic [2:0]         action;
    logic signed [15:0] a_num;
    logic signed [15:0] a_den;
    logic signed [15:0] b_num;
    logic signed [15:0] b_den;
  } in_t;

  typedef struct packed {
    logic signed [31:0] res_num;
    logic [30:0]        res_den;
    logic [1:0]         order;
    logic               error;
  } out_t;

endpackage

/* design/rational_number_alu_core.sv */
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// rational_number_alu_core: fraction add/sub/mul/div/compare/truncate
// Cross products on one shared multiplier, binary gcd and restoring division
// on one shared subtractor, all under a small one-hot sequencer.
// ----------------------------------------------------------------------------
//
//  Channel | Signals                         | Payload
//  --------+---------------------------------+-----------------------------
//  in      | in_valid_i, in_ready_o, in_i    | action, a_num, a_den, b_num, b_den
//  out     | out_valid_o, out_ready_i, out_o | res_num, res_den, order, error
//
//  One item at a time; in_ready_o is high only while the sequencer is idle.
//  Fraction actions form the products in the multiply state, combine them in the
//  sum state, reduce by the binary gcd loop and end with two bit-serial divisions,
//  numerator then denominator; a zero sum skips the gcd and the divisions.
//  Truncation runs the divider alone; errors and unused actions go straight out.
//  A finished result sits in an output register, so a stalled out channel
//  only holds the sequencer once a second result is ready. Reset is
//  asynchronous and clears only control state.
//
module rational_number_alu_core #(
  parameter int unsigned WIDTH = 16
) (
  input  logic          clk_i,
  input  logic          rst_ni,
  input  logic          in_valid_i,
  output logic          in_ready_o,
  input  rna_pkg::in_t  in_i,
  output logic          out_valid_o,
  input  logic          out_ready_i,
  output rna_pkg::out_t out_o
);

  localparam int unsigned PW = 2 * WIDTH;
  localparam int unsigned SW = PW + 2;
  localparam int unsigned CW = $clog2(PW);

  rna_pkg::state_e state_q, state_d;
  logic [CW-1:0]   cnt_q, cnt_d;
  logic            out_valid_q, out_valid_d;

  logic [2:0]       act_q, act_d;
  logic             int_q, int_d;
  logic [WIDTH-1:0] mag_q [rna_pkg::NUM_OPS];
  logic [WIDTH-1:0] mag_d [rna_pkg::NUM_OPS];
  logic             neg_q [rna_pkg::NUM_OPS];
  logic             neg_d [rna_pkg::NUM_OPS];
  logic [PW-1:0]    pa_q, pa_d, pb_q, pb_d, pd_q, pd_d;
  logic             pa_neg_q, pa_neg_d, pb_neg_q, pb_neg_d, pd_neg_q, pd_neg_d;
  logic             nneg_q, nneg_d;
  logic [1:0]       order_q, order_d;
  logic [PW-1:0]    u_q, u_d, v_q, v_d;
  logic [CW-1:0]    k_q, k_d;
  logic [PW-1:0]    dvd_q, dvd_d, rem_q, rem_d, dvs_q, dvs_d;
  rna_pkg::out_t    stg_q, stg_d, out_q, out_d;

  // Operand decode: each field is taken as a WIDTH-bit two's complement value.
  logic [WIDTH-1:0] in_raw [rna_pkg::NUM_OPS];
  logic [WIDTH-1:0] in_mag [rna_pkg::NUM_OPS];
  logic             in_neg [rna_pkg::NUM_OPS];

  assign in_raw[rna_pkg::OP_AN] = WIDTH'($unsigned(in_i.a_num));
  assign in_raw[rna_pkg::OP_AD] = WIDTH'($unsigned(in_i.a_den));
  assign in_raw[rna_pkg::OP_BN] = WIDTH'($unsigned(in_i.b_num));
  assign in_raw[rna_pkg::OP_BD] = WIDTH'($unsigned(in_i.b_den));

  always_comb begin
    for (int i = 0; i < rna_pkg::NUM_OPS; i++) begin
      in_neg[i] = in_raw[i][WIDTH-1];
      in_mag[i] = in_neg[i] ? (~in_raw[i] + WIDTH'(1)) : in_raw[i];
    end
  end

  // Shared multiplier, one product per cycle.
  logic [WIDTH-1:0] mul_x, mul_y;
  logic             mul_neg;
  logic [PW-1:0]    prod;

  always_comb begin
    case (cnt_q)
      CW'(0): begin
        mul_x   = mag_q[rna_pkg::OP_AN];
        mul_y   = (act_q == rna_pkg::ACT_MUL) ? mag_q[rna_pkg::OP_BN]
                                              : mag_q[rna_pkg::OP_BD];
        mul_neg = neg_q[rna_pkg::OP_AN] ^ ((act_q == rna_pkg::ACT_MUL) ?
                  neg_q[rna_pkg::OP_BN] : neg_q[rna_pkg::OP_BD]);
      end
      CW'(1): begin
        mul_x   = mag_q[rna_pkg::OP_BN];
        mul_y   = mag_q[rna_pkg::OP_AD];
        // Subtract and compare take the second cross product negated.
        mul_neg = neg_q[rna_pkg::OP_BN] ^ neg_q[rna_pkg::OP_AD] ^
                  ((act_q == rna_pkg::ACT_SUB) || (act_q == rna_pkg::ACT_CMP));
      end
      default: begin
        mul_x   = mag_q[rna_pkg::OP_AD];
        mul_y   = (act_q == rna_pkg::ACT_DIV) ? mag_q[rna_pkg::OP_BN]
                                              : mag_q[rna_pkg::OP_BD];
        mul_neg = neg_q[rna_pkg::OP_AD] ^ ((act_q == rna_pkg::ACT_DIV) ?
                  neg_q[rna_pkg::OP_BN] : neg_q[rna_pkg::OP_BD]);
      end
    endcase
  end

  assign prod = mul_x * mul_y;

  // Shared subtractor for the sum, the gcd steps and the divider.
  logic [SW-1:0] sub_x, sub_y, diff;
  logic          borrow;
  logic [PW-1:0] diff_abs;

  always_comb begin
    case (state_q)
      rna_pkg::ST_SUM: begin
        sub_x = {2'b00, pa_q};
        sub_y = {2'b00, pb_q};
      end
      rna_pkg::ST_GCD: begin
        sub_x = {2'b00, u_q};
        sub_y = {2'b00, v_q};
      end
      default: begin
        sub_x = {1'b0, rem_q, dvd_q[PW-1]};
        sub_y = {2'b00, dvs_q};
      end
    endcase
  end

  assign diff     = sub_x - sub_y;
  assign borrow   = diff[SW-1];
  assign diff_abs = borrow ? (~diff[PW-1:0] + PW'(1)) : diff[PW-1:0];

  // One restoring division step.
  logic [PW-1:0] rem_next, dvd_next;
  assign rem_next = borrow ? sub_x[PW-1:0] : diff[PW-1:0];
  assign dvd_next = {dvd_q[PW-2:0], ~borrow};

  // Sum of cross products (mul/div: first product), sign moved to the numerator.
  logic          same_sign;
  logic [PW-1:0] sum_mag;
  logic          sum_neg;
  logic          add_like;

  assign add_like  = (act_q == rna_pkg::ACT_ADD) || (act_q == rna_pkg::ACT_SUB) ||
                     (act_q == rna_pkg::ACT_CMP);
  assign same_sign = (pa_neg_q == pb_neg_q);

  always_comb begin
    if (!add_like) begin
      sum_mag = pa_q;
      sum_neg = pa_neg_q;
    end else if (same_sign) begin
      sum_mag = pa_q + pb_q;
      sum_neg = pa_neg_q;
    end else begin
      sum_mag = diff_abs;
      sum_neg = borrow ? pb_neg_q : pa_neg_q;
    end
  end

  function automatic logic [31:0] signed_num(logic [PW-1:0] mag, logic neg);
    logic [31:0] n32;
    n32 = 32'(mag);
    return neg ? (~n32 + 32'd1) : n32;
  endfunction

  logic in_xfer, out_load, op_err;
  assign in_xfer  = in_valid_i && in_ready_o;
  assign out_load = (state_q == rna_pkg::ST_OUT) && (!out_valid_q || out_ready_i);
  assign op_err   = (in_mag[rna_pkg::OP_AD] == '0) || (in_mag[rna_pkg::OP_BD] == '0) ||
                    ((in_i.action == rna_pkg::ACT_DIV) && (in_mag[rna_pkg::OP_BN] == '0));

  always_comb begin
    state_d  = state_q;
    cnt_d    = cnt_q;
    act_d    = act_q;
    int_d    = int_q;
    mag_d    = mag_q;
    neg_d    = neg_q;
    pa_d     = pa_q;
    pb_d     = pb_q;
    pd_d     = pd_q;
    pa_neg_d = pa_neg_q;
    pb_neg_d = pb_neg_q;
    pd_neg_d = pd_neg_q;
    nneg_d   = nneg_q;
    order_d  = order_q;
    u_d      = u_q;
    v_d      = v_q;
    k_d      = k_q;
    dvd_d    = dvd_q;
    rem_d    = rem_q;
    dvs_d    = dvs_q;
    stg_d    = stg_q;

    case (state_q)
      rna_pkg::ST_IDLE: begin
        if (in_xfer) begin
          act_d   = in_i.action;
          mag_d   = in_mag;
          neg_d   = in_neg;
          cnt_d   = '0;
          order_d = rna_pkg::ORD_NONE;
          stg_d.res_num = '0;
          stg_d.res_den = 31'd1;
          stg_d.order   = rna_pkg::ORD_NONE;
          stg_d.error   = 1'b0;
          if (in_i.action > rna_pkg::ACT_INT) begin
            state_d = rna_pkg::ST_OUT;
          end else if (in_i.action == rna_pkg::ACT_INT) begin
            if (in_mag[rna_pkg::OP_AD] == '0) begin
              stg_d.res_den = '0;
              stg_d.error   = 1'b1;
              state_d       = rna_pkg::ST_OUT;
            end else begin
              int_d   = 1'b1;
              nneg_d  = in_neg[rna_pkg::OP_AN] ^ in_neg[rna_pkg::OP_AD];
              dvd_d   = PW'(in_mag[rna_pkg::OP_AN]);
              dvs_d   = PW'(in_mag[rna_pkg::OP_AD]);
              rem_d   = '0;
              state_d = rna_pkg::ST_DIVN;
            end
          end else if (op_err) begin
            stg_d.res_den = '0;
            stg_d.error   = 1'b1;
            state_d       = rna_pkg::ST_OUT;
          end else begin
            int_d   = 1'b0;
            state_d = rna_pkg::ST_MUL;
          end
        end
      end

      rna_pkg::ST_MUL: begin
        case (cnt_q)
          CW'(0): begin
            pa_d     = prod;
            pa_neg_d = mul_neg;
          end
          CW'(1): begin
            pb_d     = prod;
            pb_neg_d = mul_neg;
          end
          default: begin
            pd_d     = prod;
            pd_neg_d = mul_neg;
          end
        endcase
        if (cnt_q == CW'(rna_pkg::MUL_STEPS - 1)) begin
          cnt_d   = '0;
          state_d = rna_pkg::ST_SUM;
        end else begin
          cnt_d = cnt_q + CW'(1);
        end
      end

      rna_pkg::ST_SUM: begin
        pa_d   = sum_mag;
        nneg_d = sum_neg ^ pd_neg_q;
        if (act_q == rna_pkg::ACT_CMP) begin
          if (sum_mag == '0) begin
            order_d = rna_pkg::ORD_EQUAL;
          end else if (sum_neg ^ pd_neg_q) begin
            order_d = rna_pkg::ORD_LESS;
          end else begin
            order_d = rna_pkg::ORD_GREATER;
          end
        end
        if (sum_mag == '0) begin
          stg_d.res_num = '0;
          stg_d.res_den = 31'd1;
          stg_d.order   = order_d;
          stg_d.error   = 1'b0;
          state_d       = rna_pkg::ST_OUT;
        end else begin
          u_d     = sum_mag;
          v_d     = pd_q;
          k_d     = '0;
          state_d = rna_pkg::ST_GCD;
        end
      end

      rna_pkg::ST_GCD: begin
        // Binary gcd: common factors of two first, then halve and subtract.
        if (u_q == '0) begin
          dvs_d   = v_q << k_q;
          dvd_d   = pa_q;
          rem_d   = '0;
          cnt_d   = '0;
          state_d = rna_pkg::ST_DIVN;
        end else if (!u_q[0] && !v_q[0]) begin
          u_d = u_q >> 1;
          v_d = v_q >> 1;
          k_d = k_q + CW'(1);
        end else if (!u_q[0]) begin
          u_d = u_q >> 1;
        end else if (!v_q[0]) begin
          v_d = v_q >> 1;
        end else if (!borrow) begin
          u_d = diff_abs >> 1;
        end else begin
          v_d = diff_abs >> 1;
        end
      end

      rna_pkg::ST_DIVN: begin
        dvd_d = dvd_next;
        rem_d = rem_next;
        cnt_d = cnt_q + CW'(1);
        if (cnt_q == CW'(PW - 1)) begin
          cnt_d = '0;
          if (int_q) begin
            stg_d.res_num = signed_num(dvd_next, nneg_q);
            stg_d.res_den = 31'd1;
            stg_d.order   = rna_pkg::ORD_NONE;
            stg_d.error   = 1'b0;
            state_d       = rna_pkg::ST_OUT;
          end else begin
            // Numerator quotient done; the divisor stays for the denominator.
            pa_d    = dvd_next;
            dvd_d   = pd_q;
            rem_d   = '0;
            state_d = rna_pkg::ST_DIVD;
          end
        end
      end

      rna_pkg::ST_DIVD: begin
        dvd_d = dvd_next;
        rem_d = rem_next;
        cnt_d = cnt_q + CW'(1);
        if (cnt_q == CW'(PW - 1)) begin
          cnt_d         = '0;
          stg_d.res_num = signed_num(pa_q, nneg_q);
          stg_d.res_den = 31'(dvd_next);
          stg_d.order   = order_q;
          stg_d.error   = 1'b0;
          state_d       = rna_pkg::ST_OUT;
        end
      end

      rna_pkg::ST_OUT: begin
        if (out_load) begin
          state_d = rna_pkg::ST_IDLE;
        end
      end

      default: begin
        state_d = rna_pkg::ST_IDLE;
      end
    endcase
  end

  always_comb begin
    out_d       = out_q;
    out_valid_d = out_valid_q && !out_ready_i;
    if (out_load) begin
      out_d       = stg_q;
      out_valid_d = 1'b1;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q     <= rna_pkg::ST_IDLE;
      cnt_q       <= '0;
      int_q       <= 1'b0;
      out_valid_q <= 1'b0;
    end else begin
      state_q     <= state_d;
      cnt_q       <= cnt_d;
      int_q       <= int_d;
      out_valid_q <= out_valid_d;
    end
  end

  always_ff @(posedge clk_i) begin
    act_q    <= act_d;
    mag_q    <= mag_d;
    neg_q    <= neg_d;
    pa_q     <= pa_d;
    pb_q     <= pb_d;
    pd_q     <= pd_d;
    pa_neg_q <= pa_neg_d;
    pb_neg_q <= pb_neg_d;
    pd_neg_q <= pd_neg_d;
    nneg_q   <= nneg_d;
    order_q  <= order_d;
    u_q      <= u_d;
    v_q      <= v_d;
    k_q      <= k_d;
    dvd_q    <= dvd_d;
    rem_q    <= rem_d;
    dvs_q    <= dvs_d;
    stg_q    <= stg_d;
    out_q    <= out_d;
  end

  assign in_ready_o  = (state_q == rna_pkg::ST_IDLE);
  assign out_valid_o = out_valid_q;
  assign out_o       = out_q;

  // The divider never runs with a zero divisor.
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    (state_q == rna_pkg::ST_DIVN || state_q == rna_pkg::ST_DIVD) |-> (dvs_q != '0))
    else $error("divider running with zero divisor");

  // The gcd loop always keeps a nonzero second value.
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    (state_q == rna_pkg::ST_GCD) |-> (v_q != '0))
    else $error("gcd lost its nonzero operand");

  // An error result carries a zero fraction and no order.
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    (out_valid_o && out_o.error) |->
      (out_o.res_num == '0 && out_o.res_den == '0 && out_o.order == rna_pkg::ORD_NONE))
    else $error("error result with nonzero payload");

  // A new result only appears after the sequencer has finished an item.
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    $rose(out_valid_q) |-> ($past(state_q) == rna_pkg::ST_OUT))
    else $error("result raised outside the output state");

endmodule
